FILE: rtl/core/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Shared sizes, codes and controller/datapath interface types for the
// stack with search and sort.
// ----------------------------------------------------------------------------
package sws_pkg;

    localparam int DEPTH       = 8;
    localparam int MAX_RESULTS = 8;
    localparam int WORD_W      = 32;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int MATCH_W     = $clog2(MAX_RESULTS + 1);
    localparam int OPC_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 3;
    localparam int FILL_W      = 4;

    typedef enum logic [OPC_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_SORT   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_PUSH,
        DP_PUSH_FULL,
        DP_POP_RD,
        DP_POP_EMIT,
        DP_POP_EMPTY,
        DP_SRCH_RD,
        DP_SRCH_CMP,
        DP_SRCH_END,
        DP_SORT_RDI,
        DP_SORT_LDI,
        DP_SORT_RDJ,
        DP_SORT_CMP,
        DP_SORT_WRI,
        DP_SORT_END
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    out_free;
        logic    full;
        logic    empty;
        logic    i_last;
        logic    j_last;
        logic    j_eq_i;
        logic    hit;
        logic    pend_valid;
        logic    match_at_max;
    } dp_status_t;

endpackage

FILE: rtl/core/sws_ctrl.sv
// ----------------------------------------------------------------------------
// sws_ctrl
// Sequencer: accepts a word, then steps the datapath through push, pop,
// linear search or exchange sort, holding at result steps while the output
// register is full and stalled.
// ----------------------------------------------------------------------------
module sws_ctrl
    import sws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP_EMIT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SRCH_END,
        S_SORT_RDI,
        S_SORT_LDI,
        S_SORT_RDJ,
        S_SORT_CMP,
        S_SORT_WRI,
        S_SORT_END
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (st.op)
                    OP_PUSH:
                    begin
                        if (st.out_free)
                        begin
                            cmd.op     = st.full ? DP_PUSH_FULL : DP_PUSH;
                            state_next = S_IDLE;
                        end
                    end
                    OP_POP:
                    begin
                        if (!st.empty)
                        begin
                            cmd.op     = DP_POP_RD;
                            state_next = S_POP_EMIT;
                        end
                        else if (st.out_free)
                        begin
                            cmd.op     = DP_POP_EMPTY;
                            state_next = S_IDLE;
                        end
                    end
                    OP_SEARCH:
                    begin
                        state_next = st.empty ? S_SRCH_END : S_SRCH_RD;
                    end
                    OP_SORT:
                    begin
                        state_next = st.empty ? S_SORT_END : S_SORT_RDI;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_POP_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.op     = DP_POP_EMIT;
                    state_next = S_IDLE;
                end
            end
            S_SRCH_RD:
            begin
                cmd.op     = DP_SRCH_RD;
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (!(st.hit && st.pend_valid && !st.out_free))
                begin
                    cmd.op = DP_SRCH_CMP;
                    if ((st.hit && st.match_at_max) || st.j_last)
                    begin
                        state_next = S_SRCH_END;
                    end
                    else
                    begin
                        state_next = S_SRCH_RD;
                    end
                end
            end
            S_SRCH_END:
            begin
                if (st.out_free)
                begin
                    cmd.op     = DP_SRCH_END;
                    state_next = S_IDLE;
                end
            end
            S_SORT_RDI:
            begin
                cmd.op     = DP_SORT_RDI;
                state_next = S_SORT_LDI;
            end
            S_SORT_LDI:
            begin
                cmd.op     = DP_SORT_LDI;
                state_next = S_SORT_RDJ;
            end
            S_SORT_RDJ:
            begin
                cmd.op     = DP_SORT_RDJ;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                cmd.op     = DP_SORT_CMP;
                state_next = st.j_last ? S_SORT_WRI : S_SORT_RDJ;
            end
            S_SORT_WRI:
            begin
                cmd.op     = DP_SORT_WRI;
                state_next = st.i_last ? S_SORT_END : S_SORT_RDI;
            end
            S_SORT_END:
            begin
                if (st.out_free)
                begin
                    cmd.op     = DP_SORT_END;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/sws_datapath.sv
// ----------------------------------------------------------------------------
// sws_datapath
// Entry store, fill count, loop indices, sort hold register, search match
// tracking and the output register.
// ----------------------------------------------------------------------------
module sws_datapath
    import sws_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    cmd,
    output dp_status_t                 st,
    input  logic [OPC_W-1:0]           opcode,
    input  logic signed [WORD_W-1:0]  operand_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic signed [WORD_W-1:0]  item_value,
    output logic [POS_W-1:0]           position,
    output logic [FILL_W-1:0]          fill_count,
    output logic                       last
);

    logic [WORD_W-1:0]  mem [DEPTH];
    logic [WORD_W-1:0]  rdata_reg;

    opcode_t            op_reg;
    logic [WORD_W-1:0]  opnd_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [ADDR_W-1:0]  i_reg;
    logic [ADDR_W-1:0]  j_reg;
    logic [WORD_W-1:0]  cur_reg;
    logic               pend_valid_reg;
    logic [ADDR_W-1:0]  pend_pos_reg;
    logic [MATCH_W-1:0] match_cnt_reg;

    logic               out_valid_reg;
    status_t            status_reg;
    logic [WORD_W-1:0]  value_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic               last_reg;

    logic [ADDR_W-1:0]  last_idx;
    logic [ADDR_W-1:0]  top_idx;
    logic               hit;
    logic               swap;

    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]  wr_data;

    logic               emit;
    status_t            e_status;
    logic [WORD_W-1:0]  e_value;
    logic [ADDR_W-1:0]  e_pos;
    logic               e_last;

    assign last_idx = ADDR_W'(count_reg - CNT_W'(1));
    assign top_idx  = last_idx;
    assign hit      = (rdata_reg == opnd_reg);
    assign swap     = ($signed(cur_reg) < $signed(rdata_reg));

    assign st.op           = op_reg;
    assign st.out_free     = !out_valid_reg || !out_stall;
    assign st.full         = (count_reg == CNT_W'(DEPTH));
    assign st.empty        = (count_reg == '0);
    assign st.i_last       = (i_reg == last_idx);
    assign st.j_last       = (j_reg == last_idx);
    assign st.j_eq_i       = (j_reg == i_reg);
    assign st.hit          = hit;
    assign st.pend_valid   = pend_valid_reg;
    assign st.match_at_max = (match_cnt_reg == MATCH_W'(MAX_RESULTS - 1));

    // memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = j_reg;
        wr_en   = 1'b0;
        wr_addr = j_reg;
        wr_data = cur_reg;
        unique case (cmd.op)
            DP_PUSH:
            begin
                wr_en   = 1'b1;
                wr_addr = ADDR_W'(count_reg);
                wr_data = opnd_reg;
            end
            DP_POP_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = top_idx;
            end
            DP_SRCH_RD, DP_SORT_RDJ:
            begin
                rd_en = 1'b1;
            end
            DP_SORT_RDI:
            begin
                rd_en   = 1'b1;
                rd_addr = i_reg;
            end
            DP_SORT_CMP:
            begin
                wr_en = !st.j_eq_i && swap;
            end
            DP_SORT_WRI:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // fill count after this step
    always_comb
    begin
        count_next = count_reg;
        unique case (cmd.op)
            DP_PUSH:     count_next = count_reg + CNT_W'(1);
            DP_POP_EMIT: count_next = count_reg - CNT_W'(1);
            default:     count_next = count_reg;
        endcase
    end

    // result word
    always_comb
    begin
        emit     = 1'b0;
        e_status = ST_OK;
        e_value  = '0;
        e_pos    = '0;
        e_last   = 1'b1;
        unique case (cmd.op)
            DP_PUSH, DP_SORT_END:
            begin
                emit = 1'b1;
            end
            DP_PUSH_FULL:
            begin
                emit     = 1'b1;
                e_status = ST_FULL;
            end
            DP_POP_EMPTY:
            begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
            end
            DP_POP_EMIT:
            begin
                emit    = 1'b1;
                e_value = rdata_reg;
            end
            DP_SRCH_CMP:
            begin
                emit    = hit && pend_valid_reg;
                e_value = opnd_reg;
                e_pos   = pend_pos_reg;
                e_last  = 1'b0;
            end
            DP_SRCH_END:
            begin
                emit = 1'b1;
                if (pend_valid_reg)
                begin
                    e_value = opnd_reg;
                    e_pos   = pend_pos_reg;
                end
                else
                begin
                    e_status = ST_NOT_FOUND;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.op == DP_LOAD)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.op == DP_SRCH_CMP && hit)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_LOAD:
            begin
                op_reg        <= opcode_t'(opcode);
                opnd_reg      <= operand_value;
                i_reg         <= '0;
                j_reg         <= '0;
                match_cnt_reg <= '0;
            end
            DP_SRCH_CMP:
            begin
                if (hit)
                begin
                    pend_pos_reg  <= j_reg;
                    match_cnt_reg <= match_cnt_reg + MATCH_W'(1);
                end
                j_reg <= j_reg + ADDR_W'(1);
            end
            DP_SORT_LDI:
            begin
                cur_reg <= rdata_reg;
                j_reg   <= '0;
            end
            DP_SORT_CMP:
            begin
                if (!st.j_eq_i && swap)
                begin
                    cur_reg <= rdata_reg;
                end
                j_reg <= j_reg + ADDR_W'(1);
            end
            DP_SORT_WRI:
            begin
                i_reg <= i_reg + ADDR_W'(1);
            end
            default:
            begin
            end
        endcase
        if (emit)
        begin
            status_reg <= e_status;
            value_reg  <= e_value;
            pos_reg    <= POS_W'(e_pos);
            fill_reg   <= FILL_W'(count_next);
            last_reg   <= e_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign item_value = value_reg;
    assign position   = pos_reg;
    assign fill_count = fill_reg;
    assign last       = last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(emit && out_valid_reg && out_stall))
        else $error("result issued into a stalled output register");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_PUSH) |-> (count_reg < CNT_W'(DEPTH)))
        else $error("push issued on a full stack");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_POP_RD) |=> (cmd.op == DP_NOP || cmd.op == DP_POP_EMIT))
        else $error("pop read not followed by its result");

    a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (match_cnt_reg != '0))
        else $error("pending match without a match count");

endmodule

FILE: rtl/core/stack_with_search_and_sort_core.sv
// ----------------------------------------------------------------------------
// stack_with_search_and_sort_core
// Bounded stack of signed words with push, pop, linear search and
// in-place exchange sort of the filled entries.
//
//   channel  signals                                  direction
//   in       in_valid, in_stall, opcode,              word in
//            operand_value
//   out      out_valid, out_stall, status,            word out
//            item_value, position, fill_count, last
//
// One operation at a time; the entry store has one read and one write port.
// Reset clears the fill level; store contents are undefined until written.
// Output stall holds the sequencer at each result step; search keeps the
// latest match pending so the final one can carry last.
// ----------------------------------------------------------------------------
module stack_with_search_and_sort_core
    import sws_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [OPC_W-1:0]           opcode,
    input  logic signed [WORD_W-1:0]  operand_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic signed [WORD_W-1:0]  item_value,
    output logic [POS_W-1:0]           position,
    output logic [FILL_W-1:0]          fill_count,
    output logic                       last
);

    dp_cmd_t    cmd;
    dp_status_t st;

    sws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    sws_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .opcode        (opcode),
        .operand_value (operand_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .item_value    (item_value),
        .position      (position),
        .fill_count    (fill_count),
        .last          (last)
    );

endmodule
